FILE: design/keyed_latency_stats_table_defines.svh
`ifndef KEYED_LATENCY_STATS_TABLE_DEFINES_SVH
`define KEYED_LATENCY_STATS_TABLE_DEFINES_SVH

// same-cycle check
`define KLS_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle check
`define KLS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/kls_pkg.sv
package kls_pkg;

	localparam int KEY_W       = 32;
	localparam int CALLS_W     = 32;
	localparam int WIDE_W      = 64;
	localparam int NUM_SLOTS_D = 32;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_DUMP   = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [CALLS_W-1:0] calls;
		logic [WIDE_W-1:0]  total;
		logic [WIDE_W-1:0]  worst;
	} slot_t;

	typedef struct packed {
		logic grant;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REC,
		ST_DUMP,
		ST_SPILL
	} state_t;

endpackage

FILE: design/kls_channels.sv
interface kls_item_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [kls_pkg::KEY_W-1:0]  request_code;
	logic [kls_pkg::WIDE_W-1:0] duration_ns;

	modport source (output valid, kind, request_code, duration_ns, input ready);
	modport sink (input valid, kind, request_code, duration_ns, output ready);
endinterface

interface kls_result_if;
	logic                       valid;
	logic                       ready;
	logic                       is_overflow;
	logic [kls_pkg::KEY_W-1:0]  request_key;
	logic [kls_pkg::WIDE_W-1:0] call_count;
	logic [kls_pkg::WIDE_W-1:0] total_ns;
	logic [kls_pkg::WIDE_W-1:0] worst_ns;
	logic                       last;

	modport source (output valid, is_overflow, request_key, call_count, total_ns, worst_ns,
		last, input ready);
	modport sink (input valid, is_overflow, request_key, call_count, total_ns, worst_ns,
		last, output ready);
endinterface

FILE: design/kls_cell.sv
module kls_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kls_pkg::cell_ctl_t         ctl,
	input  logic [kls_pkg::KEY_W-1:0]  code,
	input  logic [kls_pkg::WIDE_W-1:0] dur,
	input  kls_pkg::slot_t             from_next,
	output kls_pkg::slot_t             slot,
	output logic                       hit
);

	logic [kls_pkg::KEY_W-1:0]   key_q;
	logic [kls_pkg::CALLS_W-1:0] calls_q;
	logic [kls_pkg::WIDE_W-1:0]  total_q;
	logic [kls_pkg::WIDE_W-1:0]  worst_q;
	logic                        empty;

	assign empty = (calls_q == '0);
	assign hit   = empty || (key_q == code);

	assign slot.key   = key_q;
	assign slot.calls = calls_q;
	assign slot.total = total_q;
	assign slot.worst = worst_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= from_next.key;
		end else if (ctl.grant && empty) begin
			key_q <= code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calls_q <= '0;
			total_q <= '0;
			worst_q <= '0;
		end else if (ctl.shift) begin
			calls_q <= from_next.calls;
			total_q <= from_next.total;
			worst_q <= from_next.worst;
		end else if (ctl.grant) begin
			if (calls_q != '1) begin
				calls_q <= calls_q + 1'b1;
			end
			total_q <= total_q + dur;
			if (dur > worst_q) begin
				worst_q <= dur;
			end
		end
	end

endmodule

FILE: design/keyed_latency_stats_table.sv
// channel  modport  payload
// item     sink     kind, request_code, duration_ns
// result   source   is_overflow, request_key, call_count, total_ns, worst_ns, last
//
// record: the item is taken in idle, then the row compares and updates in the record state
// dump: the item is taken, the row moves out in NUM_SLOTS shifts, then the overflow record loads;
//   a shift with cell 0 occupied and the overflow load wait while the output register is full
// reset clears counts, totals and worst times in every cell; keys are not reset
// item ready only between items; a result waits in the output register for its transfer
`include "keyed_latency_stats_table_defines.svh"

module keyed_latency_stats_table #(
	parameter int NUM_SLOTS = kls_pkg::NUM_SLOTS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	kls_item_if.sink             item,
	kls_result_if.source         result
);

	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	kls_pkg::state_t             state_q, state_d;
	logic [kls_pkg::KEY_W-1:0]   code_q;
	logic [kls_pkg::WIDE_W-1:0]  dur_q;
	logic [CNT_W-1:0]            step_q;
	logic [kls_pkg::WIDE_W-1:0]  spill_calls_q;
	logic [kls_pkg::WIDE_W-1:0]  spill_total_q;

	logic                        ov_q;
	logic                        o_ovf_q;
	logic                        o_last_q;
	logic [kls_pkg::KEY_W-1:0]   o_key_q;
	logic [kls_pkg::WIDE_W-1:0]  o_calls_q;
	logic [kls_pkg::WIDE_W-1:0]  o_total_q;
	logic [kls_pkg::WIDE_W-1:0]  o_worst_q;

	kls_pkg::slot_t              slots [NUM_SLOTS];
	kls_pkg::slot_t              nexts [NUM_SLOTS];
	kls_pkg::cell_ctl_t          ctls  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]        hits;
	logic [NUM_SLOTS-1:0]        occ;
	logic [NUM_SLOTS-1:0]        grant;
	logic                        any_hit;

	logic                        in_xfer;
	logic                        out_free;
	logic                        do_shift;
	logic                        load_slot;
	logic                        load_spill;
	logic                        spill_upd;

	assign in_xfer  = item.valid && item.ready;
	assign out_free = !ov_q || result.ready;
	assign grant    = hits & (~hits + 1'b1);
	assign any_hit  = |hits;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
			if (gi == NUM_SLOTS - 1) begin : g_end
				assign nexts[gi] = '0;
			end else begin : g_mid
				assign nexts[gi] = slots[gi+1];
			end
			assign occ[gi]        = (slots[gi].calls != '0);
			assign ctls[gi].grant = (state_q == kls_pkg::ST_REC) && grant[gi];
			assign ctls[gi].shift = do_shift;

			kls_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctls[gi]),
				.code      (code_q),
				.dur       (dur_q),
				.from_next (nexts[gi]),
				.slot      (slots[gi]),
				.hit       (hits[gi])
			);
		end
	endgenerate

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		do_shift   = 1'b0;
		load_slot  = 1'b0;
		load_spill = 1'b0;
		spill_upd  = 1'b0;
		case (state_q)
			kls_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = (item.kind == kls_pkg::KIND_DUMP) ?
						kls_pkg::ST_DUMP : kls_pkg::ST_REC;
				end
			end
			kls_pkg::ST_REC: begin
				spill_upd = !any_hit;
				state_d   = kls_pkg::ST_IDLE;
			end
			kls_pkg::ST_DUMP: begin
				if (!occ[0] || out_free) begin
					do_shift  = 1'b1;
					load_slot = occ[0];
					if (step_q == CNT_W'(NUM_SLOTS - 1)) begin
						state_d = kls_pkg::ST_SPILL;
					end
				end
			end
			kls_pkg::ST_SPILL: begin
				if (out_free) begin
					load_spill = 1'b1;
					state_d    = kls_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kls_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			code_q <= item.request_code;
			dur_q  <= item.duration_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (in_xfer) begin
			step_q <= '0;
		end else if (do_shift) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spill_calls_q <= '0;
			spill_total_q <= '0;
		end else if (load_spill) begin
			spill_calls_q <= '0;
			spill_total_q <= '0;
		end else if (spill_upd) begin
			if (spill_calls_q != '1) begin
				spill_calls_q <= spill_calls_q + 1'b1;
			end
			spill_total_q <= spill_total_q + dur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_slot || load_spill) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_slot) begin
			o_ovf_q   <= 1'b0;
			o_last_q  <= 1'b0;
			o_key_q   <= slots[0].key;
			o_calls_q <= kls_pkg::WIDE_W'(slots[0].calls);
			o_total_q <= slots[0].total;
			o_worst_q <= slots[0].worst;
		end else if (load_spill) begin
			o_ovf_q   <= 1'b1;
			o_last_q  <= 1'b1;
			o_key_q   <= '0;
			o_calls_q <= spill_calls_q;
			o_total_q <= spill_total_q;
			o_worst_q <= '0;
		end
	end

	assign result.valid       = ov_q;
	assign result.is_overflow = o_ovf_q;
	assign result.last        = o_last_q;
	assign result.request_key = o_key_q;
	assign result.call_count  = o_calls_q;
	assign result.total_ns    = o_total_q;
	assign result.worst_ns    = o_worst_q;

	`KLS_ASSERT_NOW(a_one_grant, state_q == kls_pkg::ST_REC, $onehot0(grant), "several cells granted")
	`KLS_ASSERT_NOW(a_row_empty, state_q == kls_pkg::ST_SPILL, occ == '0, "row not empty after dump")
	`KLS_ASSERT_NEXT(a_busy, in_xfer, state_q != kls_pkg::ST_IDLE, "item transfer left block idle")

endmodule

FILE: test/tb_keyed_latency_stats_table.sv
module tb_keyed_latency_stats_table;

	localparam int ITEMS = 200;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [kls_pkg::KEY_W-1:0] MAX_KEY = '1;
	localparam logic [kls_pkg::WIDE_W-1:0] MAX_NS = '1;

	typedef struct packed {
		logic                        is_overflow;
		logic [kls_pkg::KEY_W-1:0]   request_key;
		logic [kls_pkg::WIDE_W-1:0]  call_count;
		logic [kls_pkg::WIDE_W-1:0]  total_ns;
		logic [kls_pkg::WIDE_W-1:0]  worst_ns;
		logic                        last;
	} stat_rec_t;

	typedef struct {
		logic                       kind;
		logic [kls_pkg::KEY_W-1:0]  code;
		logic [kls_pkg::WIDE_W-1:0] dur;
		int                         n_typed;
		stat_rec_t                  typed0;
		stat_rec_t                  typed1;
	} stim_row_t;

	localparam stat_rec_t EMPTY_SPILL = {1'b1, {kls_pkg::KEY_W{1'b0}},
		{kls_pkg::WIDE_W{1'b0}}, {kls_pkg::WIDE_W{1'b0}}, {kls_pkg::WIDE_W{1'b0}}, 1'b1};
	localparam stat_rec_t NO_REC = '0;

	logic clk;
	logic arst_n;

	kls_item_if   item_ch();
	kls_result_if result_ch();

	keyed_latency_stats_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// predictor state
	logic [kls_pkg::KEY_W-1:0]   tab_key   [kls_pkg::NUM_SLOTS_D];
	logic [kls_pkg::CALLS_W-1:0] tab_calls [kls_pkg::NUM_SLOTS_D];
	logic [kls_pkg::WIDE_W-1:0]  tab_total [kls_pkg::NUM_SLOTS_D];
	logic [kls_pkg::WIDE_W-1:0]  tab_worst [kls_pkg::NUM_SLOTS_D];
	logic [kls_pkg::WIDE_W-1:0]  spill_calls;
	logic [kls_pkg::WIDE_W-1:0]  spill_total;

	stat_rec_t fresh[$];
	stat_rec_t due_recs[$];
	stim_row_t plan[$];

	int  errors = 0;
	int  cycles = 0;
	int  sent = 0;
	bit  quiet = 0;
	bit  calm = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_keyed_latency_stats_table: errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [kls_pkg::WIDE_W-1:0] got,
		input logic [kls_pkg::WIDE_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic clear_tab();
		for (int i = 0; i < kls_pkg::NUM_SLOTS_D; i++) begin
			tab_key[i]   = '0;
			tab_calls[i] = '0;
			tab_total[i] = '0;
			tab_worst[i] = '0;
		end
		spill_calls = '0;
		spill_total = '0;
	endtask

	// work out the records one item causes, into fresh
	task automatic tally_item(input logic kind, input logic [kls_pkg::KEY_W-1:0] code,
		input logic [kls_pkg::WIDE_W-1:0] dur);
		int hit;
		stat_rec_t rec;
		hit = -1;
		fresh.delete();
		if (kind == kls_pkg::KIND_RECORD) begin
			for (int i = 0; i < kls_pkg::NUM_SLOTS_D; i++) begin
				if (hit < 0 && (tab_calls[i] == '0 || tab_key[i] == code))
					hit = i;
			end
			if (hit >= 0) begin
				if (tab_calls[hit] == '0)
					tab_key[hit] = code;
				if (tab_calls[hit] != '1)
					tab_calls[hit] = tab_calls[hit] + 1'b1;
				tab_total[hit] = tab_total[hit] + dur;
				if (dur > tab_worst[hit])
					tab_worst[hit] = dur;
			end else begin
				if (spill_calls != '1)
					spill_calls = spill_calls + 1'b1;
				spill_total = spill_total + dur;
			end
		end else begin
			for (int i = 0; i < kls_pkg::NUM_SLOTS_D; i++) begin
				if (tab_calls[i] != '0) begin
					rec.is_overflow = 1'b0;
					rec.request_key = tab_key[i];
					rec.call_count  = {{(kls_pkg::WIDE_W-kls_pkg::CALLS_W){1'b0}}, tab_calls[i]};
					rec.total_ns    = tab_total[i];
					rec.worst_ns    = tab_worst[i];
					rec.last        = 1'b0;
					fresh.push_back(rec);
				end
			end
			rec.is_overflow = 1'b1;
			rec.request_key = '0;
			rec.call_count  = spill_calls;
			rec.total_ns    = spill_total;
			rec.worst_ns    = '0;
			rec.last        = 1'b1;
			fresh.push_back(rec);
			clear_tab();
		end
	endtask

	function automatic stim_row_t mk_row(input logic kind, input logic [kls_pkg::KEY_W-1:0] code,
		input logic [kls_pkg::WIDE_W-1:0] dur, input int n, input stat_rec_t t0,
		input stat_rec_t t1);
		stim_row_t r;
		r.kind    = kind;
		r.code    = code;
		r.dur     = dur;
		r.n_typed = n;
		r.typed0  = t0;
		r.typed1  = t1;
		return r;
	endfunction

	function automatic logic [kls_pkg::WIDE_W-1:0] pick_ns();
		logic [kls_pkg::WIDE_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = MAX_NS;
			2: v = {$urandom, $urandom};
			3: v = kls_pkg::WIDE_W'($urandom_range(0, 1000));
			4: v = MAX_NS - kls_pkg::WIDE_W'($urandom_range(0, 1000));
			default: v = kls_pkg::WIDE_W'(1) << $urandom_range(0, kls_pkg::WIDE_W-1);
		endcase
		return v;
	endfunction

	task automatic put_item(input stim_row_t r);
		int gap;
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.kind         <= r.kind;
		item_ch.request_code <= r.code;
		item_ch.duration_ns  <= r.dur;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		sent++;
		tally_item(r.kind, r.code, r.dur);
		if (r.n_typed == 0) begin
			foreach (fresh[i]) due_recs.push_back(fresh[i]);
		end else begin
			if (r.n_typed > 1)
				due_recs.push_back(r.typed0);
			due_recs.push_back(r.n_typed > 1 ? r.typed1 : r.typed0);
		end
	endtask

	// result side stalls
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 15);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		stat_rec_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (due_recs.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				want = due_recs.pop_front();
				check_field("is_overflow", result_ch.is_overflow, want.is_overflow);
				check_field("request_key", result_ch.request_key, want.request_key);
				check_field("call_count", result_ch.call_count, want.call_count);
				check_field("total_ns", result_ch.total_ns, want.total_ns);
				check_field("worst_ns", result_ch.worst_ns, want.worst_ns);
				check_field("last", result_ch.last, want.last);
			end
		end
	end

	initial begin
		logic [kls_pkg::KEY_W-1:0] keys [40];
		logic [kls_pkg::KEY_W-1:0] base;
		int pool;
		int n;
		arst_n               <= 1'b0;
		item_ch.valid        <= 1'b0;
		item_ch.kind         <= kls_pkg::KIND_RECORD;
		item_ch.request_code <= '0;
		item_ch.duration_ns  <= '0;
		clear_tab();

		// directed rows
		plan.push_back(mk_row(kls_pkg::KIND_DUMP, MAX_KEY, MAX_NS, 1, EMPTY_SPILL, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, MAX_KEY, MAX_NS, 0, NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_DUMP, '0, '0, 2,
			{1'b0, MAX_KEY, 64'd1, MAX_NS, MAX_NS, 1'b0}, EMPTY_SPILL));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, '0, '0, 0, NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, '0, 64'd5, 0, NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_DUMP, 32'h1234_5678, 64'd9, 2,
			{1'b0, 32'd0, 64'd2, 64'd5, 64'd5, 1'b0}, EMPTY_SPILL));
		// total wraps, worst stays at max
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, 32'd1, MAX_NS, 0, NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, 32'd1, 64'd2, 0, NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_DUMP, '0, '0, 2,
			{1'b0, 32'd1, 64'd2, 64'd1, MAX_NS, 1'b0}, EMPTY_SPILL));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, 32'h8000_0000, 64'h8000_0000_0000_0000, 0,
			NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, 0,
			NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, 32'h8000_0000, 64'd1, 0, NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, 32'haaaa_aaaa, 64'h5555_5555_5555_5555, 0,
			NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, 32'h5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 0,
			NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, 32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, 0,
			NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_DUMP, 32'hdead_beef, MAX_NS, 0, NO_REC, NO_REC));
		// table was cleared by the dump above
		plan.push_back(mk_row(kls_pkg::KIND_DUMP, '0, '0, 1, EMPTY_SPILL, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_RECORD, 32'd5, '0, 0, NO_REC, NO_REC));
		plan.push_back(mk_row(kls_pkg::KIND_DUMP, '0, '0, 2,
			{1'b0, 32'd5, 64'd1, 64'd0, 64'd0, 1'b0}, EMPTY_SPILL));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) put_item(plan[i]);

		// random sessions of records closed by a dump
		while (sent < ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			quiet = (sent > ITEMS - 40);
			pool = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 32);
			base = $urandom;
			for (int k = 0; k < 40; k++)
				keys[k] = ($urandom_range(0, 1) == 0) ? base + kls_pkg::KEY_W'(k) :
					kls_pkg::KEY_W'($urandom);
			if ($urandom_range(0, 7) == 0)
				keys[$urandom_range(0, pool-1)] = ($urandom_range(0, 1) == 0) ? '0 : MAX_KEY;
			n = (pool > kls_pkg::NUM_SLOTS_D) ? $urandom_range(40, 60) : $urandom_range(0, 30);
			for (int j = 0; j < n && sent < ITEMS - 1; j++) begin
				if ($urandom_range(0, 24) == 0)
					put_item(mk_row(kls_pkg::KIND_DUMP, $urandom, pick_ns(), 0, NO_REC, NO_REC));
				else
					put_item(mk_row(kls_pkg::KIND_RECORD, keys[$urandom_range(0, pool-1)],
						pick_ns(), 0, NO_REC, NO_REC));
			end
			put_item(mk_row(kls_pkg::KIND_DUMP, $urandom, pick_ns(), 0, NO_REC, NO_REC));
		end
		item_ch.valid <= 1'b0;

		while (due_recs.size() != 0) @(posedge clk);
		repeat (kls_pkg::NUM_SLOTS_D + 8) @(posedge clk);
		if (errors == 0)
			$display("tb_keyed_latency_stats_table: clean");
		else
			$display("tb_keyed_latency_stats_table: errors");
		$finish;
	end

endmodule
